// ===== rtl/ptbb_pkg.sv =====
// Shared types and constants for the path bounding box block.
`timescale 1ns / 1ps
package ptbb_pkg;
   localparam logic [1:0] ACT_MOVE  = 2'd0;
   localparam logic [1:0] ACT_LINE  = 2'd1;
   localparam logic [1:0] ACT_CUBIC = 2'd2;
   localparam logic [1:0] ACT_CLOSE = 2'd3;
   localparam int REQ_BITS = 200;
   localparam int RSP_BITS = 128;

   // input transfer, fields from the highest bit down
   typedef struct packed {
      logic signed [31:0] point_c_y;
      logic signed [31:0] point_c_x;
      logic signed [31:0] point_b_y;
      logic signed [31:0] point_b_x;
      logic signed [31:0] point_a_y;
      logic signed [31:0] point_a_x;
      logic [5:0]         pad;
      logic [1:0]         action;
   } req_data_type;
endpackage

// ===== rtl/path_tight_bounding_box.sv =====
// Top level of the path bounding box block: sequencer, shared divider, root and lerp unit.
`timescale 1ns / 1ps
// A move, line or close passes through S_DONE before req_tready is high again.
// A cubic takes up to two square roots, up to four divisions of PARAM_FRAC_BITS quotient
// bits each and up to four curve evaluations of de Casteljau lerps for x and then y,
// all on one shared unit. A box is registered in S_EMIT after S_DONE, once the last box is taken.
// Throughput: one transfer at a time; req_tready is low while a command is at work.
// Reset: synchronous, active high; clears the box, the current point and the handshake.
module path_tight_bounding_box #(
   parameter int PARAM_FRAC_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // action[1:0], 6 zero bits, point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y
   input  logic [ptbb_pkg::REQ_BITS-1:0] req_tdata,
   input  logic         req_tlast,        // last_item
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // origin_x, origin_y, box_width, box_height
   output logic [ptbb_pkg::RSP_BITS-1:0] rsp_tdata,
   output logic         rsp_tuser         // box_empty
);
   import ptbb_pkg::*;

   localparam int TW = PARAM_FRAC_BITS;
   localparam int CW = $clog2(TW + 1) > 6 ? $clog2(TW + 1) : 6;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_COEF  = 4'd1;
   localparam logic [3:0] S_DISC  = 4'd2;
   localparam logic [3:0] S_SQRT  = 4'd3;
   localparam logic [3:0] S_DIV   = 4'd4;
   localparam logic [3:0] S_NEXTQ = 4'd5;
   localparam logic [3:0] S_EVAL  = 4'd6;
   localparam logic [3:0] S_ADD   = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;
   localparam logic [3:0] S_EMIT  = 4'd9;
   localparam logic [3:0] S_HH    = 4'd10;

   req_data_type req_d;
   assign req_d = req_data_type'(req_tdata);

   logic [3:0]  state_ff;
   logic        any_ff, started_ff, last_ff;
   logic signed [31:0] cur_x_ff, cur_y_ff, min_x_ff, min_y_ff, max_x_ff, max_y_ff;
   logic signed [31:0] px_ff [4];
   logic signed [31:0] py_ff [4];
   logic        axis_ff;        // 0 x, 1 y
   logic signed [35:0] a_ff, h_ff, c_ff;
   logic [71:0] d_ff;
   logic [35:0] s_ff;          // sqrt result built bit by bit
   logic [5:0]  sbit_ff;
   logic [1:0]  quot_ff;       // which quotient of this axis
   logic [36:0] un_ff, ud_ff;
   logic [TW-1:0] q_ff;
   logic [CW-1:0] cnt_ff;
   logic [TW-1:0] ts_ff [4];
   logic [2:0]  nt_ff, ei_ff;
   logic [3:0]  lstep_ff;
   logic signed [31:0] lv_ff [5];
   logic signed [31:0] ex_ff;
   logic        rv_ff, re_ff;
   logic [127:0] rd_ff;

   // shared lerp: p + floor((q-p)*t / 2^TW)
   function automatic logic signed [31:0] lerp(input logic signed [31:0] p,
                                               input logic signed [31:0] q,
                                               input logic [TW-1:0] t);
      logic signed [32:0] d;
      logic signed [33+TW:0] pr;
      logic signed [33+TW:0] sh;
      begin
         d  = 33'(q) - 33'(p);
         pr = (34+TW)'(d) * $signed({1'b0, t});
         sh = pr >>> TW;
         lerp = 32'(34'(p) + sh[33:0]);
      end
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = re_ff;

   // lerp operand selection for the de Casteljau step counter
   logic signed [31:0] lp, lq, lr;
   logic signed [31:0] pt [4];
   always_comb begin
      for (int i = 0; i < 4; i++) pt[i] = lstep_ff[3] ? py_ff[i] : px_ff[i];
      case (lstep_ff[2:0])
         3'd0: begin lp = pt[0]; lq = pt[1]; end
         3'd1: begin lp = pt[1]; lq = pt[2]; end
         3'd2: begin lp = pt[2]; lq = pt[3]; end
         3'd3: begin lp = lv_ff[0]; lq = lv_ff[1]; end
         3'd4: begin lp = lv_ff[1]; lq = lv_ff[2]; end
         default: begin lp = lv_ff[3]; lq = lv_ff[4]; end
      endcase
      lr = lerp(lp, lq, ts_ff[ei_ff[1:0]]);
   end

   // sqrt trial and divider step
   logic [35:0] trial;
   logic [71:0] tsq;
   logic [37:0] r2;
   assign trial = s_ff | (36'd1 << sbit_ff);
   assign tsq   = trial * trial;
   assign r2    = {un_ff, 1'b0};

   logic signed [31:0] p0, p1, p2, p3;
   assign p0 = axis_ff ? py_ff[0] : px_ff[0];
   assign p1 = axis_ff ? py_ff[1] : px_ff[1];
   assign p2 = axis_ff ? py_ff[2] : px_ff[2];
   assign p3 = axis_ff ? py_ff[3] : px_ff[3];

   logic [35:0] mh, ma, mc;
   assign mh = h_ff[35] ? 36'(-h_ff) : 36'(h_ff);
   assign ma = a_ff[35] ? 36'(-a_ff) : 36'(a_ff);
   assign mc = c_ff[35] ? 36'(-c_ff) : 36'(c_ff);

   // box accumulation of one point
   task automatic addp(input logic signed [31:0] x, input logic signed [31:0] y,
                       inout logic a, inout logic signed [31:0] nx, inout logic signed [31:0] xx,
                       inout logic signed [31:0] ny, inout logic signed [31:0] xy);
      if (!a) begin
         nx = x; xx = x; ny = y; xy = y; a = 1'b1;
      end else begin
         if (x < nx) nx = x;
         if (x > xx) xx = x;
         if (y < ny) ny = y;
         if (y > xy) xy = y;
      end
   endtask

   logic signed [36:0] den_s;
   logic signed [36:0] nsel;
   always_comb begin
      den_s = (a_ff == 36'sd0) ? 37'(h_ff) <<< 1 : 37'(a_ff);
      nsel  = (a_ff == 36'sd0) ? -37'(c_ff)
            : (quot_ff == 2'd0) ? -37'(h_ff) + 37'($signed({1'b0, s_ff}))
            : -37'(h_ff) - 37'($signed({1'b0, s_ff}));
   end

   always_ff @(posedge clock) begin
      logic a; logic signed [31:0] nx, xx, ny, xy;
      a = any_ff; nx = min_x_ff; xx = max_x_ff; ny = min_y_ff; xy = max_y_ff;
      if (reset) begin
         state_ff <= S_IDLE; rv_ff <= 1'b0; any_ff <= 1'b0; started_ff <= 1'b0;
         cur_x_ff <= '0; cur_y_ff <= '0; min_x_ff <= '0; min_y_ff <= '0;
         max_x_ff <= '0; max_y_ff <= '0; last_ff <= 1'b0;
      end else begin
         if (rv_ff && rsp_tready) rv_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (req_tvalid && req_tready) begin
               last_ff <= req_tlast;
               state_ff <= (req_d.action == ACT_CUBIC) ? S_COEF : S_DONE;
               case (req_d.action)
                  ACT_MOVE: begin
                     addp(req_d.point_a_x, req_d.point_a_y, a, nx, xx, ny, xy);
                     cur_x_ff <= req_d.point_a_x; cur_y_ff <= req_d.point_a_y;
                     started_ff <= 1'b1;
                  end
                  ACT_LINE: begin
                     if (!started_ff) addp(32'sd0, 32'sd0, a, nx, xx, ny, xy);
                     addp(req_d.point_a_x, req_d.point_a_y, a, nx, xx, ny, xy);
                     cur_x_ff <= req_d.point_a_x; cur_y_ff <= req_d.point_a_y;
                     started_ff <= 1'b1;
                  end
                  ACT_CUBIC: begin
                     px_ff[0] <= started_ff ? cur_x_ff : 32'sd0;
                     py_ff[0] <= started_ff ? cur_y_ff : 32'sd0;
                     px_ff[1] <= req_d.point_a_x; py_ff[1] <= req_d.point_a_y;
                     px_ff[2] <= req_d.point_b_x; py_ff[2] <= req_d.point_b_y;
                     px_ff[3] <= req_d.point_c_x; py_ff[3] <= req_d.point_c_y;
                     addp(started_ff ? cur_x_ff : 32'sd0, started_ff ? cur_y_ff : 32'sd0,
                          a, nx, xx, ny, xy);
                     addp(req_d.point_c_x, req_d.point_c_y, a, nx, xx, ny, xy);
                     cur_x_ff <= req_d.point_c_x; cur_y_ff <= req_d.point_c_y;
                     started_ff <= 1'b1;
                     axis_ff <= 1'b0; nt_ff <= '0;
                  end
                  default: ;
               endcase
            end
            S_COEF: begin
               a_ff <= -36'(p0) + 36'sd3 * 36'(p1) - 36'sd3 * 36'(p2) + 36'(p3);
               h_ff <= 36'(p0) - 36'sd2 * 36'(p1) + 36'(p2);
               c_ff <= 36'(p1) - 36'(p0);
               quot_ff <= 2'd0;
               state_ff <= S_HH;
            end
            S_HH: begin
               if (a_ff == 36'sd0) begin
                  state_ff <= (h_ff == 36'sd0) ? S_NEXTQ : S_DIV;
                  quot_ff <= 2'd1;
                  cnt_ff <= '0;
               end else begin
                  d_ff <= mh * mh;
                  state_ff <= S_DISC;
               end
            end
            S_DISC: begin
               // d_ff holds H*H; form the discriminant with one product
               if (c_ff != 36'sd0 && (a_ff[35] != c_ff[35])) begin
                  d_ff <= d_ff + ma * mc; state_ff <= S_SQRT;
               end else if (ma * mc > d_ff) begin
                  // negative discriminant: skip both quotients of this axis
                  quot_ff <= 2'd1; state_ff <= S_NEXTQ;
               end else begin
                  d_ff <= d_ff - ma * mc; state_ff <= S_SQRT;
               end
               s_ff <= '0; sbit_ff <= 6'd35;
            end
            S_SQRT: begin
               if (tsq <= d_ff) s_ff <= trial;
               if (sbit_ff == 6'd0) begin
                  state_ff <= S_DIV; cnt_ff <= '0;
               end else sbit_ff <= sbit_ff - 6'd1;
            end
            S_DIV: begin
               if (cnt_ff == '0) begin
                  // set up operands; reject a zero or opposite-signed operand and fractions not below one
                  un_ff <= nsel[36] ? 37'(-nsel) : 37'(nsel);
                  ud_ff <= den_s[36] ? 37'(-den_s) : 37'(den_s);
                  q_ff <= '0;
                  if (nsel == '0 || den_s == '0 || nsel[36] != den_s[36] ||
                      (nsel[36] ? 37'(-nsel) : 37'(nsel)) >=
                      (den_s[36] ? 37'(-den_s) : 37'(den_s)))
                     state_ff <= S_NEXTQ;
                  else cnt_ff <= cnt_ff + 1'b1;
               end else begin
                  if (r2 >= {1'b0, ud_ff}) begin
                     un_ff <= 37'(r2 - {1'b0, ud_ff}); q_ff <= {q_ff[TW-2:0], 1'b1};
                  end else begin
                     un_ff <= r2[36:0]; q_ff <= {q_ff[TW-2:0], 1'b0};
                  end
                  if (cnt_ff == CW'(TW)) state_ff <= S_ADD;
                  else cnt_ff <= cnt_ff + 1'b1;
               end
            end
            S_ADD: begin
               if (q_ff != '0) begin
                  ts_ff[nt_ff[1:0]] <= q_ff; nt_ff <= nt_ff + 3'd1;
               end
               state_ff <= S_NEXTQ;
            end
            S_NEXTQ: begin
               if (quot_ff == 2'd0 && a_ff != 36'sd0) begin
                  quot_ff <= 2'd1; cnt_ff <= '0; state_ff <= S_DIV;
               end else if (!axis_ff) begin
                  axis_ff <= 1'b1; state_ff <= S_COEF;
               end else if (nt_ff != 3'd0) begin
                  ei_ff <= '0; lstep_ff <= '0; state_ff <= S_EVAL;
               end else state_ff <= S_DONE;
            end
            S_EVAL: begin
               if (lstep_ff[2:0] == 3'd5) begin
                  if (!lstep_ff[3]) begin
                     ex_ff <= lr; lstep_ff <= 4'd8;
                  end else begin
                     addp(ex_ff, lr, a, nx, xx, ny, xy);
                     lstep_ff <= '0;
                     if (ei_ff + 3'd1 == nt_ff) state_ff <= S_DONE;
                     ei_ff <= ei_ff + 3'd1;
                  end
               end else begin
                  lv_ff[lstep_ff[2:0]] <= lr;
                  lstep_ff <= lstep_ff + 4'd1;
               end
            end
            S_DONE: begin
               if (last_ff) state_ff <= S_EMIT;
               else state_ff <= S_IDLE;
            end
            S_EMIT: if (!rv_ff) begin
               rv_ff <= 1'b1;
               re_ff <= !any_ff;
               rd_ff <= any_ff ? {32'(max_y_ff - min_y_ff), 32'(max_x_ff - min_x_ff),
                                  min_y_ff, min_x_ff} : '0;
               started_ff <= 1'b0; cur_x_ff <= '0; cur_y_ff <= '0;
               nx = '0; xx = '0; ny = '0; xy = '0; a = 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         if (state_ff != S_EMIT || !rv_ff) begin
            any_ff <= a; min_x_ff <= nx; max_x_ff <= xx; min_y_ff <= ny; max_y_ff <= xy;
         end
      end
   end
endmodule

// ===== sim/ptbb_checker.sv =====
// Checker for the path bounding box block: predicts each emitted box and compares it.
`timescale 1ns / 1ps
module ptbb_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [ptbb_pkg::REQ_BITS-1:0] req_tdata,
   input  logic                          req_tlast,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [ptbb_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic                          rsp_tuser,
   output int                            fail_count,
   output int                            boxes_pending
);
   import ptbb_pkg::*;

   localparam int TFRAC = 24;

   typedef struct packed {
      logic [31:0] org_x;
      logic [31:0] org_y;
      logic [31:0] wid;
      logic [31:0] hgt;
      logic        empty;
   } box_type;

   box_type box_q[$];

   // running path state
   bit     has_pt, began;
   longint cur_x, cur_y, lo_x, lo_y, hi_x, hi_y;

   function automatic longint unsigned mag(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Quotient num/den as a t fraction; rejects opposite signs, den = 0, |num| >= |den| and t = 0.
   function automatic bit param_quot(input longint num, input longint den,
                                     output longint unsigned t);
      longint unsigned un, ud, q, r;
      t = 0;
      if (num == 0 || den == 0) return 0;
      if ((num < 0) != (den < 0)) return 0;
      un = mag(num);
      ud = mag(den);
      if (un >= ud) return 0;
      r = un;
      q = 0;
      for (int i = 0; i < TFRAC; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= ud) begin
            r = r - ud;
            q = q | 1;
         end
      end
      t = q;
      return q != 0;
   endfunction

   function automatic longint unsigned floor_sqrt(input logic [127:0] d);
      longint unsigned lo, hi, mid;
      logic [127:0] sq;
      lo = 0;
      hi = 64'd1 << 35;
      while (hi - lo > 1) begin
         mid = lo + (hi - lo) / 2;
         sq = {64'd0, mid} * {64'd0, mid};
         if (sq <= d) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic longint interp(input longint p, input longint q, input longint unsigned t);
      longint d;
      longint unsigned prod;
      d = q - p;
      prod = mag(d) * t;
      if (d >= 0) return p + longint'(prod >> TFRAC);
      return p - longint'(prod >> TFRAC) - ((prod[TFRAC-1:0] != 0) ? 1 : 0);
   endfunction

   function automatic longint curve_at(input longint p0, p1, p2, p3, input longint unsigned t);
      longint a, b, c;
      a = interp(p0, p1, t);
      b = interp(p1, p2, t);
      c = interp(p2, p3, t);
      return interp(interp(a, b, t), interp(b, c, t), t);
   endfunction

   // Parameters where the derivative of one coordinate vanishes inside (0,1).
   function automatic void turning_params(input longint p0, p1, p2, p3,
                                          output longint unsigned t0, t1, output int n);
      longint a, h, c, s;
      logic signed [127:0] disc;
      longint unsigned tq;
      n = 0;
      t0 = 0;
      t1 = 0;
      a = -p0 + 3 * p1 - 3 * p2 + p3;
      h = p0 - 2 * p1 + p2;
      c = p1 - p0;
      if (a == 0) begin
         if (h != 0 && param_quot(-c, 2 * h, tq)) begin
            t0 = tq;
            n = 1;
         end
         return;
      end
      disc = 128'(h) * 128'(h) - 128'(a) * 128'(c);
      if (disc < 0) return;
      s = longint'(floor_sqrt(disc));
      if (param_quot(-h + s, a, tq)) begin
         t0 = tq;
         n = 1;
      end
      if (param_quot(-h - s, a, tq)) begin
         if (n == 0) t0 = tq;
         else t1 = tq;
         n = n + 1;
      end
   endfunction

   function automatic void grow(input longint x, input longint y);
      if (!has_pt) begin
         lo_x = x; hi_x = x; lo_y = y; hi_y = y;
         has_pt = 1;
         return;
      end
      if (x < lo_x) lo_x = x;
      if (x > hi_x) hi_x = x;
      if (y < lo_y) lo_y = y;
      if (y > hi_y) hi_y = y;
   endfunction

   function automatic void clear_path();
      has_pt = 0; began = 0;
      cur_x = 0; cur_y = 0; lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
   endfunction

   function automatic void apply_cmd(input req_data_type r);
      longint ax, ay, bx, by, cx, cy, px0, py0;
      longint unsigned tx0, tx1, ty0, ty1;
      longint unsigned ts[4];
      int nx, ny;
      ax = r.point_a_x; ay = r.point_a_y;
      bx = r.point_b_x; by = r.point_b_y;
      cx = r.point_c_x; cy = r.point_c_y;
      case (r.action)
         ACT_MOVE: begin
            grow(ax, ay);
            cur_x = ax; cur_y = ay;
            began = 1;
         end
         ACT_LINE: begin
            if (!began) begin
               grow(0, 0);
               began = 1;
            end
            grow(ax, ay);
            cur_x = ax; cur_y = ay;
         end
         ACT_CUBIC: begin
            if (!began) begin
               cur_x = 0; cur_y = 0;
               began = 1;
            end
            px0 = cur_x; py0 = cur_y;
            grow(px0, py0);
            grow(cx, cy);
            turning_params(px0, ax, bx, cx, tx0, tx1, nx);
            turning_params(py0, ay, by, cy, ty0, ty1, ny);
            ts[0] = tx0; ts[1] = tx1;
            // y roots follow the x roots
            for (int i = 0; i < ny; i++) ts[nx + i] = (i == 0) ? ty0 : ty1;
            for (int i = 0; i < nx + ny; i++)
               grow(curve_at(px0, ax, bx, cx, ts[i]), curve_at(py0, ay, by, cy, ts[i]));
            cur_x = cx; cur_y = cy;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      box_type want, got;
      if (reset) begin
         clear_path();
         fail_count <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_cmd(req_data_type'(req_tdata));
            if (req_tlast) begin
               if (has_pt) begin
                  want.org_x = lo_x[31:0];
                  want.org_y = lo_y[31:0];
                  want.wid   = 32'(hi_x - lo_x);
                  want.hgt   = 32'(hi_y - lo_y);
                  want.empty = 0;
               end else begin
                  want = '{32'd0, 32'd0, 32'd0, 32'd0, 1'b1};
               end
               box_q.push_back(want);
               clear_path();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got.org_x = rsp_tdata[31:0];
            got.org_y = rsp_tdata[63:32];
            got.wid   = rsp_tdata[95:64];
            got.hgt   = rsp_tdata[127:96];
            got.empty = rsp_tuser;
            if (box_q.size() == 0) begin
               $display("%0t: unexpected box transfer %h empty=%b", $time, rsp_tdata, rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = box_q.pop_front();
               if (want != got) begin
                  $display("%0t: box mismatch expected x=%h y=%h w=%h h=%h e=%b",
                           $time, want.org_x, want.org_y, want.wid, want.hgt, want.empty);
                  $display("%0t:              actual   x=%h y=%h w=%h h=%h e=%b",
                           $time, got.org_x, got.org_y, got.wid, got.hgt, got.empty);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      boxes_pending <= box_q.size();
   end
endmodule

// ===== sim/path_tight_bounding_box_tb.sv =====
// Testbench top for the path bounding box block: stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module path_tight_bounding_box_tb;
   import ptbb_pkg::*;

   localparam int ITEM_TARGET = 900;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_tvalid = 0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata = '0;
   logic                req_tlast = 0;
   logic                rsp_tvalid;
   logic                rsp_tready = 0;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic                rsp_tuser;
   int                  fail_count;
   int                  boxes_pending;
   int                  cmds_sent = 0;
   bit                  quiet = 0;      // no idling on either side while set

   always #5 clock = ~clock;

   path_tight_bounding_box i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ptbb_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .boxes_pending (boxes_pending)
   );

   // Back-pressure on the result side: drop tready with a chance of 11 in 100 unless quiet is set.
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 11);
   end

   // Present one command and hold it until the block takes the transfer.
   // tvalid stays high between back-to-back commands; it drops only for a gap.
   task automatic send_cmd(input logic [1:0] act, input logic [31:0] ax, ay, bx, by, cx, cy,
                           input logic last);
      req_data_type r;
      if (!quiet && $urandom_range(0, 99) < 11) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      r.action = act;
      r.pad = '0;
      r.point_a_x = ax; r.point_a_y = ay;
      r.point_b_x = bx; r.point_b_y = by;
      r.point_c_x = cx; r.point_c_y = cy;
      req_tdata  <= r;
      req_tlast  <= last;
      req_tvalid <= 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmds_sent++;
   endtask

   // Coordinates: mostly small values so boxes are readable, with full-range and extremes.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         1, 2, 3: return $urandom;
         default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
      endcase
   endfunction

   task automatic random_cmd(input logic [1:0] act, input logic last);
      send_cmd(act, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
               pick_coord(), pick_coord(), last);
   endtask

   initial begin
      int len;
      logic [1:0] act;
      bit tidy;
      repeat (7) @(posedge clock);
      reset <= 0;

      // empty path, then a single point at the range extremes
      send_cmd(ACT_CLOSE, 0, 0, 0, 0, 0, 0, 1);
      send_cmd(ACT_MOVE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 1);
      // line before any move pulls in the origin
      send_cmd(ACT_LINE, 5, -3, 0, 0, 0, 0, 1);
      // cubic before any move starts from the origin
      send_cmd(ACT_CUBIC, 100, 0, -50, 200, 300, -10, 1);
      // x: zero cubic term with a single turning point; y: straight, no roots
      send_cmd(ACT_MOVE, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_CUBIC, 30, 10, 40, 20, 30, 30, 1);
      // one root inside (0,1) on x, two roots on y
      send_cmd(ACT_MOVE, -65536, 65536, 0, 0, 0, 0, 0);
      send_cmd(ACT_CUBIC, -65536 + 10, 65536 + 300000, 10, 65536 - 300000,
               -65536 + 40, 65536, 1);
      // cubic across the whole coordinate range, closed on the last command
      send_cmd(ACT_MOVE, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0);
      send_cmd(ACT_CUBIC, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 0);
      send_cmd(ACT_CLOSE, 1, 2, 3, 4, 5, 6, 1);
      // close in the middle keeps the current point
      send_cmd(ACT_MOVE, 1000, -1000, 0, 0, 0, 0, 0);
      send_cmd(ACT_CLOSE, 0, 0, 0, 0, 0, 0, 0);
      send_cmd(ACT_LINE, -70000, 90000, 0, 0, 0, 0, 0);
      send_cmd(ACT_CUBIC, 200000, 200000, -200000, -200000, 0, 0, 1);

      // random paths: mostly well formed, some noise with arbitrary command kinds
      while (cmds_sent < ITEM_TARGET) begin
         quiet = (cmds_sent > 350 && cmds_sent < 500);
         len  = $urandom_range(1, 8);
         tidy = ($urandom_range(0, 99) < 85);
         for (int i = 0; i < len; i++) begin
            if (!tidy) act = 2'($urandom_range(0, 3));
            else if (i == 0 && $urandom_range(0, 9) != 0) act = ACT_MOVE;
            else case ($urandom_range(0, 9))
               0: act = ACT_CLOSE;
               1: act = ACT_MOVE;
               2, 3, 4: act = ACT_LINE;
               default: act = ACT_CUBIC;
            endcase
            random_cmd(act, i == len - 1);
         end
      end
      quiet = 0;
      req_tvalid <= 0;

      while (boxes_pending != 0) @(posedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Guard against a hang: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
